FILE: hdl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants of the penalty contact force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    localparam logic [47:0] FORCE_CAP = 48'h8000_0000_0000;

    typedef enum logic [1:0]
    {
        REG_STIFFNESS = 2'd0,
        REG_DAMPING   = 2'd1,
        REG_USE_VEL   = 2'd2
    } cfg_idx_t;

    typedef struct packed
    {
        logic signed [47:0] spring;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic        [36:0] w;
        logic               dmp_on;
    } side_t;

endpackage

`default_nettype wire

FILE: hdl/penalty_contact_force_unit.sv
// ----------------------------------------------------------------------------
// penalty_contact_force_unit
// Linear spring-dashpot contact force for one particle pair per item.
// ----------------------------------------------------------------------------
// The unit takes one pair item per clock while the output is not stalled
// and returns one force item per pair, in order. The pipeline is fully
// stalled by m_tready: while the output register holds an untaken item
// every stage holds. Most of the depth lies in the 32-stage effective-mass
// divider and the 32-stage square root, each resolving one result bit per
// stage. Write the configuration registers only while no item is in flight.
`default_nettype none

module penalty_contact_force_unit
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    output logic            s_tready,
    // penetration, normal_x, normal_y, normal_z, vel_i_x, vel_i_y, vel_i_z,
    // vel_j_x, vel_j_y, vel_j_z, mass_first, mass_second, zero pad
    input  wire  [343:0]    s_tdata,
    output logic            m_tvalid,
    input  wire             m_tready,
    // force_x, force_y, force_z
    output logic [95:0]     m_tdata,
    input  wire             cfg_we,
    input  wire  [1:0]      cfg_index,
    input  wire  [31:0]     cfg_data
);

    logic [31:0] stiffness_reg;
    logic [31:0] damping_reg;
    logic        use_vel_reg;

    logic               en;
    logic               f_vld, d_vld, q_vld, p_vld, o_vld;
    logic        [63:0] mprod;
    logic        [32:0] msum;
    logic        [31:0] meff;
    logic        [31:0] root;
    logic signed [48:0] total;
    logic signed [31:0] force_x, force_y, force_z;
    pcf_pkg::side_t     f_side, d_side, q_side, p_side;

    assign en       = !o_vld || m_tready;
    assign s_tready = en;
    assign m_tvalid = o_vld;
    assign m_tdata  = {force_z, force_y, force_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= 32'd65536;
            damping_reg   <= 32'd0;
            use_vel_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (pcf_pkg::cfg_idx_t'(cfg_index))
                pcf_pkg::REG_STIFFNESS: stiffness_reg <= cfg_data;
                pcf_pkg::REG_DAMPING:   damping_reg   <= cfg_data;
                pcf_pkg::REG_USE_VEL:   use_vel_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    pcf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (s_tvalid & en),
        .penetration  ($signed(s_tdata[31:0])),
        .normal_x     ($signed(s_tdata[49:32])),
        .normal_y     ($signed(s_tdata[67:50])),
        .normal_z     ($signed(s_tdata[85:68])),
        .vel_i_x      ($signed(s_tdata[117:86])),
        .vel_i_y      ($signed(s_tdata[149:118])),
        .vel_i_z      ($signed(s_tdata[181:150])),
        .vel_j_x      ($signed(s_tdata[213:182])),
        .vel_j_y      ($signed(s_tdata[245:214])),
        .vel_j_z      ($signed(s_tdata[277:246])),
        .mass_first   (s_tdata[309:278]),
        .mass_second  (s_tdata[341:310]),
        .stiffness    (stiffness_reg),
        .use_velocity (use_vel_reg),
        .out_vld      (f_vld),
        .mprod        (mprod),
        .msum         (msum),
        .side         (f_side)
    );

    pcf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .mprod    (mprod),
        .msum     (msum),
        .side_in  (f_side),
        .out_vld  (d_vld),
        .meff     (meff),
        .side_out (d_side)
    );

    pcf_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (d_vld),
        .meff      (meff),
        .stiffness (stiffness_reg),
        .side_in   (d_side),
        .out_vld   (q_vld),
        .root      (root),
        .side_out  (q_side)
    );

    pcf_damp u_damp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (q_vld),
        .root     (root),
        .damping  (damping_reg),
        .side_in  (q_side),
        .out_vld  (p_vld),
        .total    (total),
        .side_out (p_side)
    );

    pcf_proj u_proj
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (p_vld),
        .total   (total),
        .side_in (p_side),
        .out_vld (o_vld),
        .force_x (force_x),
        .force_y (force_y),
        .force_z (force_z)
    );

endmodule

`default_nettype wire

FILE: hdl/pcf_front.sv
// ----------------------------------------------------------------------------
// pcf_front
// Spring force, relative normal velocity, mass product and mass sum, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_front
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire signed [31:0]   penetration,
    input  wire signed [17:0]   normal_x,
    input  wire signed [17:0]   normal_y,
    input  wire signed [17:0]   normal_z,
    input  wire signed [31:0]   vel_i_x,
    input  wire signed [31:0]   vel_i_y,
    input  wire signed [31:0]   vel_i_z,
    input  wire signed [31:0]   vel_j_x,
    input  wire signed [31:0]   vel_j_y,
    input  wire signed [31:0]   vel_j_z,
    input  wire        [31:0]   mass_first,
    input  wire        [31:0]   mass_second,
    input  wire        [31:0]   stiffness,
    input  wire                 use_velocity,
    output logic                out_vld,
    output logic       [63:0]   mprod,
    output logic       [32:0]   msum,
    output pcf_pkg::side_t      side
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [63:0] s1_reg;
    logic signed [32:0] dvx_reg, dvy_reg, dvz_reg;
    logic signed [17:0] nx1_reg, ny1_reg, nz1_reg;
    logic signed [17:0] nx2_reg, ny2_reg, nz2_reg;
    logic        [63:0] mp1_reg, mp2_reg, mp3_reg;
    logic        [32:0] ms1_reg, ms2_reg, ms3_reg;
    logic signed [47:0] sp2_reg;
    logic signed [50:0] ppx_reg, ppy_reg, ppz_reg;
    pcf_pkg::side_t     side3_reg;

    logic signed [64:0] s_full;
    logic signed [50:0] ppx_next, ppy_next, ppz_next;
    logic signed [52:0] vn;
    logic        [53:0] vneg;
    pcf_pkg::side_t     side3_next;

    assign s_full   = $signed({1'b0, stiffness}) * penetration;
    assign ppx_next = dvx_reg * nx1_reg;
    assign ppy_next = dvy_reg * ny1_reg;
    assign ppz_next = dvz_reg * nz1_reg;
    assign vn       = 53'(ppx_reg) + 53'(ppy_reg) + 53'(ppz_reg);
    assign vneg     = 54'(0) - {vn[52], vn};

    always_comb
    begin
        side3_next.spring = sp2_reg;
        side3_next.nx     = nx2_reg;
        side3_next.ny     = ny2_reg;
        side3_next.nz     = nz2_reg;
        side3_next.w      = vneg[52:16];
        side3_next.dmp_on = use_velocity & vn[52];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s_full[63:0];
            dvx_reg   <= $signed({vel_i_x[31], vel_i_x}) - $signed({vel_j_x[31], vel_j_x});
            dvy_reg   <= $signed({vel_i_y[31], vel_i_y}) - $signed({vel_j_y[31], vel_j_y});
            dvz_reg   <= $signed({vel_i_z[31], vel_i_z}) - $signed({vel_j_z[31], vel_j_z});
            nx1_reg   <= normal_x;
            ny1_reg   <= normal_y;
            nz1_reg   <= normal_z;
            mp1_reg   <= mass_first * mass_second;
            ms1_reg   <= {1'b0, mass_first} + {1'b0, mass_second};
            sp2_reg   <= s1_reg[63:16];
            ppx_reg   <= ppx_next;
            ppy_reg   <= ppy_next;
            ppz_reg   <= ppz_next;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            nz2_reg   <= nz1_reg;
            mp2_reg   <= mp1_reg;
            ms2_reg   <= ms1_reg;
            mp3_reg   <= mp2_reg;
            ms3_reg   <= ms2_reg;
            side3_reg <= side3_next;
        end
    end

    assign out_vld = v3_reg;
    assign mprod   = mp3_reg;
    assign msum    = ms3_reg;
    assign side    = side3_reg;

endmodule

`default_nettype wire

FILE: hdl/pcf_div.sv
// ----------------------------------------------------------------------------
// pcf_div
// Effective mass: restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_div
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire        [63:0]   mprod,
    input  wire        [32:0]   msum,
    input  pcf_pkg::side_t      side_in,
    output logic                out_vld,
    output logic       [31:0]   meff,
    output pcf_pkg::side_t      side_out
);

    logic               vld_reg  [32];
    logic        [32:0] rem_reg  [32];
    logic        [31:0] low_reg  [32];
    logic        [32:0] dsr_reg  [32];
    pcf_pkg::side_t     side_reg [32];

    logic        [32:0] rem_src  [32];
    logic        [31:0] low_src  [32];
    logic        [32:0] dsr_src  [32];
    logic        [33:0] trial    [32];
    logic        [33:0] diff     [32];
    logic        [32:0] rem_next [32];
    logic        [31:0] low_next [32];

    always_comb
    begin
        rem_src[0] = {1'b0, mprod[63:32]};
        low_src[0] = mprod[31:0];
        dsr_src[0] = msum;
        for (int i = 1; i < 32; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            low_src[i] = low_reg[i-1];
            dsr_src[i] = dsr_reg[i-1];
        end
        for (int i = 0; i < 32; i++)
        begin
            trial[i] = {rem_src[i], low_src[i][31]};
            diff[i]  = trial[i] - {1'b0, dsr_src[i]};
            if (trial[i] >= {1'b0, dsr_src[i]})
            begin
                rem_next[i] = diff[i][32:0];
                low_next[i] = {low_src[i][30:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][32:0];
                low_next[i] = {low_src[i][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < 32; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < 32; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < 32; i++)
            begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                dsr_reg[i] <= dsr_src[i];
            end
        end
    end

    assign out_vld  = vld_reg[31];
    assign meff     = (dsr_reg[31] == 33'd0) ? 32'd0 : low_reg[31];
    assign side_out = side_reg[31];

endmodule

`default_nettype wire

FILE: hdl/pcf_sqrt.sv
// ----------------------------------------------------------------------------
// pcf_sqrt
// Critical damping root: stiffness times effective mass, then a digit-by-digit
// square root with one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_sqrt
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire        [31:0]   meff,
    input  wire        [31:0]   stiffness,
    input  pcf_pkg::side_t      side_in,
    output logic                out_vld,
    output logic       [31:0]   root,
    output pcf_pkg::side_t      side_out
);

    logic               vm_reg;
    logic        [63:0] km_reg;
    pcf_pkg::side_t     sm_reg;

    logic               vld_reg  [32];
    logic        [33:0] rem_reg  [32];
    logic        [31:0] rt_reg   [32];
    logic        [63:0] bits_reg [32];
    pcf_pkg::side_t     side_reg [32];

    logic        [33:0] rem_src  [32];
    logic        [31:0] rt_src   [32];
    logic        [63:0] bits_src [32];
    logic        [35:0] trial    [32];
    logic        [35:0] cand     [32];
    logic        [35:0] diff     [32];
    logic        [33:0] rem_next [32];
    logic        [31:0] rt_next  [32];

    always_comb
    begin
        rem_src[0]  = 34'd0;
        rt_src[0]   = 32'd0;
        bits_src[0] = km_reg;
        for (int i = 1; i < 32; i++)
        begin
            rem_src[i]  = rem_reg[i-1];
            rt_src[i]   = rt_reg[i-1];
            bits_src[i] = bits_reg[i-1];
        end
        for (int i = 0; i < 32; i++)
        begin
            trial[i] = {rem_src[i], bits_src[i][63:62]};
            cand[i]  = {2'b00, rt_src[i], 2'b01};
            diff[i]  = trial[i] - cand[i];
            if (trial[i] >= cand[i])
            begin
                rem_next[i] = diff[i][33:0];
                rt_next[i]  = {rt_src[i][30:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][33:0];
                rt_next[i]  = {rt_src[i][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            for (int i = 0; i < 32; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vm_reg     <= in_vld;
            vld_reg[0] <= vm_reg;
            for (int i = 1; i < 32; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            km_reg      <= stiffness * meff;
            sm_reg      <= side_in;
            side_reg[0] <= sm_reg;
            for (int i = 1; i < 32; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < 32; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                rt_reg[i]   <= rt_next[i];
                bits_reg[i] <= {bits_src[i][61:0], 2'b00};
            end
        end
    end

    assign out_vld  = vld_reg[31];
    assign root     = rt_reg[31];
    assign side_out = side_reg[31];

endmodule

`default_nettype wire

FILE: hdl/pcf_damp.sv
// ----------------------------------------------------------------------------
// pcf_damp
// Dashpot force and total: gain, split wide product, cap, add spring force.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_damp
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire        [31:0]   root,
    input  wire        [31:0]   damping,
    input  pcf_pkg::side_t      side_in,
    output logic                out_vld,
    output logic signed [48:0]  total,
    output pcf_pkg::side_t      side_out
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    pcf_pkg::side_t     s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic        [63:0] gp_reg;
    logic        [63:0] pll_reg;
    logic        [36:0] plh_reg;
    logic        [48:0] phl_reg;
    logic        [21:0] phh_reg;
    logic        [85:0] prod_reg;
    logic        [47:0] d_reg;
    logic signed [48:0] total_reg;

    logic        [48:0] g;
    logic        [85:0] prod_next;
    logic        [47:0] d_next;

    assign g         = {gp_reg[63:16], 1'b0};
    assign prod_next = {22'd0, pll_reg} + {17'd0, plh_reg, 32'd0}
                     + {5'd0, phl_reg, 32'd0} + {phh_reg, 64'd0};

    always_comb
    begin
        if (!s3_reg.dmp_on)
        begin
            d_next = 48'd0;
        end
        else if (prod_reg[85:16] > 70'(pcf_pkg::FORCE_CAP))
        begin
            d_next = pcf_pkg::FORCE_CAP;
        end
        else
        begin
            d_next = prod_reg[63:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= side_in;
            s2_reg    <= s1_reg;
            s3_reg    <= s2_reg;
            s4_reg    <= s3_reg;
            s5_reg    <= s4_reg;
            gp_reg    <= damping * root;
            pll_reg   <= g[31:0] * s1_reg.w[31:0];
            plh_reg   <= g[31:0] * s1_reg.w[36:32];
            phl_reg   <= g[48:32] * s1_reg.w[31:0];
            phh_reg   <= g[48:32] * s1_reg.w[36:32];
            prod_reg  <= prod_next;
            d_reg     <= d_next;
            total_reg <= $signed({s4_reg.spring[47], s4_reg.spring}) + $signed({1'b0, d_reg});
        end
    end

    assign out_vld  = v5_reg;
    assign total    = total_reg;
    assign side_out = s5_reg;

endmodule

`default_nettype wire

FILE: hdl/pcf_proj.sv
// ----------------------------------------------------------------------------
// pcf_proj
// Clamp the total force, project it onto the normal and saturate; the last
// stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_proj
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire signed [48:0]   total,
    input  pcf_pkg::side_t      side_in,
    output logic                out_vld,
    output logic signed [31:0]  force_x,
    output logic signed [31:0]  force_y,
    output logic signed [31:0]  force_z
);

    logic               v1_reg, v2_reg, v3_reg;
    logic        [47:0] f_reg;
    logic signed [17:0] n1_reg  [3];
    logic        [49:0] hi_reg  [3];
    logic        [17:0] lo_reg  [3];
    logic               neg_reg [3];
    logic signed [31:0] out_reg [3];

    logic        [47:0] f_next;
    logic        [17:0] an      [3];
    logic        [33:0] lo_full [3];
    logic        [50:0] mag     [3];
    logic signed [31:0] out_next [3];

    always_comb
    begin
        if (total <= 49'sd0)
        begin
            f_next = 48'd0;
        end
        else if (total > $signed({1'b0, pcf_pkg::FORCE_CAP}))
        begin
            f_next = pcf_pkg::FORCE_CAP;
        end
        else
        begin
            f_next = total[47:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            an[c]      = n1_reg[c][17] ? 18'(-n1_reg[c]) : n1_reg[c];
            lo_full[c] = f_reg[15:0] * an[c];
            mag[c]     = {1'b0, hi_reg[c]} + {33'd0, lo_reg[c]};
            if (neg_reg[c])
            begin
                out_next[c] = (mag[c] > 51'h8000_0000) ? 32'sh8000_0000 : 32'(51'd0 - mag[c]);
            end
            else
            begin
                out_next[c] = (mag[c] > 51'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[c][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg     <= f_next;
            n1_reg[0] <= side_in.nx;
            n1_reg[1] <= side_in.ny;
            n1_reg[2] <= side_in.nz;
            for (int c = 0; c < 3; c++)
            begin
                hi_reg[c]  <= f_reg[47:16] * an[c];
                lo_reg[c]  <= lo_full[c][33:16];
                neg_reg[c] <= n1_reg[c][17];
                out_reg[c] <= out_next[c];
            end
        end
    end

    assign out_vld = v3_reg;
    assign force_x = out_reg[0];
    assign force_y = out_reg[1];
    assign force_z = out_reg[2];

endmodule

`default_nettype wire

FILE: tb/penalty_contact_force_unit_test.sv
// ----------------------------------------------------------------------------
// penalty_contact_force_unit_test
// Streams contact pairs through the force unit under several register
// settings, predicts every force vector in the testbench and compares the
// items in order, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module penalty_contact_force_unit_test;

    localparam logic [63:0] CAP = 64'h0000_8000_0000_0000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed
    {
        logic [31:0] mass_second;
        logic [31:0] mass_first;
        logic [31:0] vjz;
        logic [31:0] vjy;
        logic [31:0] vjx;
        logic [31:0] viz;
        logic [31:0] viy;
        logic [31:0] vix;
        logic [17:0] nz;
        logic [17:0] ny;
        logic [17:0] nx;
        logic [31:0] penetration;
    } pair_t;

    typedef struct packed
    {
        logic [31:0] fz;
        logic [31:0] fy;
        logic [31:0] fx;
    } force_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [343:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;
    logic cfg_we = 0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] k_reg;
    logic [31:0] damp_reg;
    logic use_vel_reg;

    pair_t pending_pairs[$];
    force_t expected_forces[$];
    int errors = 0;
    int pairs_sent = 0;
    int forces_seen = 0;
    bit idle_free = 0;
    bit hold_sink = 0;

    penalty_contact_force_unit DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] project_axis(logic [63:0] f, logic signed [17:0] n);
        logic [63:0] an;
        logic [63:0] mag;
        an = n < 0 ? 64'(-64'(n)) : 64'(n);
        mag = (f >> 16) * an + (((f & 64'hFFFF) * an) >> 16);
        if (n < 0)
            return mag > 64'h8000_0000 ? 32'h8000_0000 : 32'(-mag);
        return mag > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic force_t contact_force(pair_t p);
        logic signed [63:0] s;
        logic signed [63:0] spring;
        logic signed [63:0] total;
        logic signed [63:0] vn;
        logic [63:0] w;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] meff;
        logic [63:0] g;
        logic [127:0] prod;
        logic [63:0] dmp;
        logic [63:0] f;
        force_t r;
        s = $signed({32'd0, k_reg}) * 64'($signed(p.penetration));
        if (s >= 0)
            spring = s >>> 16;
        else
            spring = -64'((64'(-s) + 64'hFFFF) >> 16);
        dmp = 0;
        if (use_vel_reg)
        begin
            vn = (64'($signed(p.vix)) - 64'($signed(p.vjx))) * 64'($signed(p.nx))
               + (64'($signed(p.viy)) - 64'($signed(p.vjy))) * 64'($signed(p.ny))
               + (64'($signed(p.viz)) - 64'($signed(p.vjz))) * 64'($signed(p.nz));
            if (vn < 0)
            begin
                w = 64'(-vn) >> 16;
                m1 = p.mass_first;
                m2 = p.mass_second;
                meff = (m1 + m2) == 0 ? 0 : (m1 * m2) / (m1 + m2);
                g = ((64'(damp_reg) * int_sqrt(64'(k_reg) * meff)) >> 16) * 2;
                prod = 128'(g) * 128'(w);
                if (g == 0 || w == 0)
                    dmp = 0;
                else if (prod[127:64] != 0)
                    dmp = CAP;
                else
                    dmp = (prod[63:0] >> 16) > CAP ? CAP : prod[63:0] >> 16;
            end
        end
        total = spring + $signed(dmp);
        if (total <= 0)
            f = 0;
        else
            f = 64'(total) > CAP ? CAP : 64'(total);
        r.fx = project_axis(f, p.nx);
        r.fy = project_axis(f, p.ny);
        r.fz = project_axis(f, p.nz);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            expected_forces.push_back(contact_force(pair_t'(s_tdata[341:0])));
            pairs_sent++;
        end
        if ((!s_tvalid || s_tready) && pending_pairs.size() > 0
            && (idle_free || $urandom_range(99) >= 25))
        begin
            s_tvalid <= 1;
            s_tdata <= {2'd0, pending_pairs.pop_front()};
        end
        else if (!s_tvalid || s_tready)
            s_tvalid <= 0;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            force_t got;
            force_t want;
            got = force_t'(m_tdata);
            forces_seen++;
            if (expected_forces.size() == 0)
            begin
                $error("force item with none expected");
                errors++;
            end
            else
            begin
                want = expected_forces.pop_front();
                if (got.fx !== want.fx)
                begin
                    $error("force_x expected %h got %h", want.fx, got.fx);
                    errors++;
                end
                if (got.fy !== want.fy)
                begin
                    $error("force_y expected %h got %h", want.fy, got.fy);
                    errors++;
                end
                if (got.fz !== want.fz)
                begin
                    $error("force_z expected %h got %h", want.fz, got.fz);
                    errors++;
                end
            end
        end
        m_tready <= !hold_sink && (idle_free || $urandom_range(99) >= 25);
    end

    task automatic write_reg(pcf_pkg::cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            pcf_pkg::REG_STIFFNESS: k_reg = val;
            pcf_pkg::REG_DAMPING: damp_reg = val;
            pcf_pkg::REG_USE_VEL: use_vel_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (pending_pairs.size() > 0 || s_tvalid || expected_forces.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [17:0] rand_normal();
        case ($urandom_range(5))
            0: return 18'h10000;
            1: return 18'h30000;
            2: return 18'h20000;
            3: return 18'h1FFFF;
            default: return 18'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(300000);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        p.penetration = $urandom_range(3) == 0 ? rand_word() : $urandom_range(200000);
        p.nx = rand_normal();
        p.ny = rand_normal();
        p.nz = rand_normal();
        p.vix = rand_word();
        p.viy = rand_word();
        p.viz = rand_word();
        p.vjx = rand_word();
        p.vjy = rand_word();
        p.vjz = rand_word();
        p.mass_first = $urandom_range(4) == 0 ? 0 : rand_word();
        p.mass_second = $urandom_range(4) == 0 ? 0 : rand_word();
        return p;
    endfunction

    task automatic add_directed();
        pair_t p;
        p = '0;
        p.nx = 18'h10000;
        p.penetration = 32'h0001_0000;
        pending_pairs.push_back(p);
        p.penetration = 32'hFFFF_0000;
        pending_pairs.push_back(p);
        p.penetration = 32'h7FFF_FFFF;
        p.nx = 18'h30000;
        p.ny = 18'h1FFFF;
        p.nz = 18'h20000;
        pending_pairs.push_back(p);
        p.penetration = 32'h8000_0000;
        pending_pairs.push_back(p);
        p = '0;
        p.penetration = 32'h0000_8000;
        p.nx = 18'h10000;
        p.vix = 32'h8000_0000;
        p.vjx = 32'h7FFF_FFFF;
        p.mass_first = 32'hFFFF_FFFF;
        p.mass_second = 32'hFFFF_FFFF;
        pending_pairs.push_back(p);
        p.vix = 32'h7FFF_FFFF;
        p.vjx = 32'h8000_0000;
        pending_pairs.push_back(p);
        p.vix = 32'hFFFF_0000;
        p.vjx = 32'h0;
        p.mass_first = 0;
        p.mass_second = 0;
        pending_pairs.push_back(p);
        p.ny = 18'h0B505;
        p.nz = 18'h3FFFF;
        p.viy = 32'hFFFE_0000;
        p.viz = 32'h0003_0000;
        p.mass_first = 32'h0001_0000;
        pending_pairs.push_back(p);
        p.penetration = 32'hFFFF_FFFF;
        p.mass_second = 32'h0002_0000;
        pending_pairs.push_back(p);
    endtask

    initial
    begin
        int i;
        int hold;
        k_reg = 32'h0001_0000;
        damp_reg = 0;
        use_vel_reg = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        add_directed();
        drain_all();
        write_reg(pcf_pkg::REG_DAMPING, 32'h0000_8000);
        add_directed();
        drain_all();
        write_reg(pcf_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(pcf_pkg::REG_DAMPING, 32'hFFFF_FFFF);
        add_directed();
        drain_all();
        write_reg(pcf_pkg::REG_USE_VEL, 32'd0);
        write_reg(pcf_pkg::REG_STIFFNESS, 32'd0);
        add_directed();
        drain_all();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(pcf_pkg::REG_STIFFNESS,
                      phase == 5 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0010_0000));
            write_reg(pcf_pkg::REG_DAMPING,
                      phase == 4 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0002_0000));
            write_reg(pcf_pkg::REG_USE_VEL, 32'(phase != 2));
            idle_free = (phase == 1);
            for (i = 0; i < 100; i++)
                pending_pairs.push_back(rand_pair());
            if (phase == 3)
            begin
                hold_sink = 1;
                hold = 0;
                while (hold < 300)
                begin
                    @(posedge clk);
                    hold++;
                end
                hold_sink = 0;
            end
            drain_all();
        end

        $display("Covered %0d pairs and %0d force items over ten register settings,",
                 pairs_sent, forces_seen);
        $display("including zero/extreme stiffness, damping off/on and a full output stall.");
        if (errors == 0)
            $display("[penalty_contact_force_unit] OK");
        else
            $display("[penalty_contact_force_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[penalty_contact_force_unit] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pcf_pkg.sv
hdl/pcf_front.sv
hdl/pcf_div.sv
hdl/pcf_sqrt.sv
hdl/pcf_damp.sv
hdl/pcf_proj.sv
hdl/penalty_contact_force_unit.sv
tb/penalty_contact_force_unit_test.sv
